// File: rtl/hsl2rgb_pkg.sv
// Shared constants, types and helper functions of the HSL to RGB converter.
package hsl2rgb_pkg;

  // Saturation and lightness format: unsigned, FRAC_BITS fraction bits
  localparam int FRAC_BITS = 12;
  localparam int SL_W      = FRAC_BITS + 1;
  localparam logic [SL_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // Hue: Q4 degrees, one turn is 5760 units
  localparam int HUE_IN_W  = 16;
  localparam int HUE_W     = 13;
  localparam int HUE_TURN  = 5760;
  localparam int HUE_THIRD = 1920;
  localparam int HUE_SEG   = 960;     // one sixth of a turn
  localparam int SEG_W     = 10;

  // Hue wrap: bias into positive range, then floor divide by 5760 = 45 << 7
  localparam int HU_W      = 17;
  localparam int HUE_BIAS  = 6 * HUE_TURN;
  localparam int HUE_LSB   = 7;
  localparam int RECIP_45  = 1457;    // ceil(2^16 / 45), exact for values below 2259
  localparam int RECIP_SH  = 16;
  localparam int HQ_W      = 5;
  localparam int HR_W      = HU_W - HUE_LSB;

  // Helper values M1, M2 at scale ONE*ONE
  localparam int M_W       = 2 * FRAC_BITS + 1;
  localparam int MX_W      = M_W + 2;

  // Channel scaling: byte = floor((255*X + 480*ONE^2) / (960*ONE^2))
  localparam int X_W       = M_W + SEG_W;
  localparam int Y_W       = X_W + 8;
  localparam int Z_SH      = 2 * FRAC_BITS + 6;   // 960 = 15 << 6
  localparam int Z_W       = Y_W - Z_SH;
  localparam int RECIP_15  = 4370;    // ceil(2^16 / 15), exact for values below 4681
  localparam int BYTE_W    = 8;
  localparam logic [Y_W-1:0] HALF_Y = Y_W'(HUE_SEG / 2) << (2 * FRAC_BITS);

  // Pipeline stage indices
  localparam int NUM_STG   = 6;
  localparam int ST_WRAP   = 0;
  localparam int ST_PROD   = 1;
  localparam int ST_HELP   = 2;
  localparam int ST_MUL    = 3;
  localparam int ST_SCALE  = 4;
  localparam int ST_OUT    = 5;

  typedef logic [NUM_STG-1:0] stg_en_t;

  typedef struct packed {
    logic [M_W-1:0] m1;
    logic [M_W-1:0] dlt;   // M2 - M1, never negative
  } helper_t;

  // Rotate a wrapped hue by an offset below one turn
  function automatic logic [HUE_W-1:0] hue_rot(input logic [HUE_W-1:0] t,
                                               input logic [HUE_W-1:0] offs);
    logic [HUE_W:0] sum;
    sum = {1'b0, t} + {1'b0, offs};
    if (sum >= (HUE_W+1)'(HUE_TURN)) begin
      sum = sum - (HUE_W+1)'(HUE_TURN);
    end
    return sum[HUE_W-1:0];
  endfunction

  // Position of the ramp between M1 (0) and M2 (HUE_SEG) for a wrapped hue
  function automatic logic [SEG_W-1:0] seg_frac(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] down;
    down = HUE_W'(4 * HUE_SEG) - t;
    if (t < HUE_W'(HUE_SEG)) begin
      return t[SEG_W-1:0];
    end else if (t < HUE_W'(3 * HUE_SEG)) begin
      return SEG_W'(HUE_SEG);
    end else if (t < HUE_W'(4 * HUE_SEG)) begin
      return down[SEG_W-1:0];
    end else begin
      return '0;
    end
  endfunction

endpackage

// File: rtl/hsl2rgb_if.sv
// Valid/ready channel interfaces for HSL items in and RGB items out.
interface hsl2rgb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [hsl2rgb_pkg::HUE_IN_W-1:0] hue_q4;
  logic [hsl2rgb_pkg::SL_W-1:0]           saturation;
  logic [hsl2rgb_pkg::SL_W-1:0]           lightness;
  logic [hsl2rgb_pkg::BYTE_W-1:0]         alpha_in;

  modport source (output valid, hue_q4, saturation, lightness, alpha_in, input ready);
  modport sink   (input valid, hue_q4, saturation, lightness, alpha_in, output ready);
endinterface

interface hsl2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsl2rgb_pkg::BYTE_W-1:0] red;
  logic [hsl2rgb_pkg::BYTE_W-1:0] green;
  logic [hsl2rgb_pkg::BYTE_W-1:0] blue;
  logic [hsl2rgb_pkg::BYTE_W-1:0] alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

// File: rtl/hsl2rgb_front.sv
// Front stages: clamp, hue wrap, helper values M1/M2 and per-channel ramp positions.
module hsl2rgb_front (
  input  logic                                    clk,
  input  hsl2rgb_pkg::stg_en_t                    en,
  input  logic signed [hsl2rgb_pkg::HUE_IN_W-1:0] hue_q4,
  input  logic [hsl2rgb_pkg::SL_W-1:0]            saturation,
  input  logic [hsl2rgb_pkg::SL_W-1:0]            lightness,
  output hsl2rgb_pkg::helper_t                    help,
  output logic [hsl2rgb_pkg::SEG_W-1:0]           f_red,
  output logic [hsl2rgb_pkg::SEG_W-1:0]           f_green,
  output logic [hsl2rgb_pkg::SEG_W-1:0]           f_blue
);

  // Stage 1: clamp, biased hue and its turn count
  logic [hsl2rgb_pkg::SL_W-1:0]   s_c, l_c;
  logic [hsl2rgb_pkg::HU_W-1:0]   u;
  logic [hsl2rgb_pkg::HR_W+11-1:0] qprod;
  logic [hsl2rgb_pkg::SL_W-1:0]   s1_s_r, s1_l_r;
  logic [hsl2rgb_pkg::HU_W-1:0]   s1_u_r;
  logic [hsl2rgb_pkg::HQ_W-1:0]   s1_q_r;

  assign s_c   = (saturation > hsl2rgb_pkg::ONE_Q) ? hsl2rgb_pkg::ONE_Q : saturation;
  assign l_c   = (lightness  > hsl2rgb_pkg::ONE_Q) ? hsl2rgb_pkg::ONE_Q : lightness;
  assign u     = hsl2rgb_pkg::HU_W'({hue_q4[hsl2rgb_pkg::HUE_IN_W-1], hue_q4})
               + hsl2rgb_pkg::HU_W'(hsl2rgb_pkg::HUE_BIAS);
  assign qprod = (hsl2rgb_pkg::HR_W+11)'(u[hsl2rgb_pkg::HU_W-1:hsl2rgb_pkg::HUE_LSB])
               * (hsl2rgb_pkg::HR_W+11)'(hsl2rgb_pkg::RECIP_45);

  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::ST_WRAP]) begin
      s1_s_r <= s_c;
      s1_l_r <= l_c;
      s1_u_r <= u;
      s1_q_r <= qprod[hsl2rgb_pkg::RECIP_SH +: hsl2rgb_pkg::HQ_W];
    end
  end

  // Stage 2: wrapped hue and the l*s product
  logic [hsl2rgb_pkg::HU_W-1:0]    t_full;
  logic [hsl2rgb_pkg::HUE_W-1:0]   s2_t_r;
  logic [hsl2rgb_pkg::M_W-1:0]     s2_ls_r;
  logic [hsl2rgb_pkg::SL_W-1:0]    s2_s_r, s2_l_r;
  logic                            s2_lo_r;
  logic [2*hsl2rgb_pkg::SL_W-1:0]  ls;

  assign t_full = s1_u_r - (hsl2rgb_pkg::HU_W'(s1_q_r) * hsl2rgb_pkg::HU_W'(hsl2rgb_pkg::HUE_TURN));
  assign ls     = (2*hsl2rgb_pkg::SL_W)'(s1_l_r) * (2*hsl2rgb_pkg::SL_W)'(s1_s_r);

  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::ST_PROD]) begin
      s2_t_r  <= t_full[hsl2rgb_pkg::HUE_W-1:0];
      s2_ls_r <= ls[hsl2rgb_pkg::M_W-1:0];
      s2_s_r  <= s1_s_r;
      s2_l_r  <= s1_l_r;
      s2_lo_r <= ({s1_l_r, 1'b0} <= {1'b0, hsl2rgb_pkg::ONE_Q});
    end
  end

  // Stage 3: M2, M1 and the ramp positions of the three channels
  logic [hsl2rgb_pkg::MX_W-1:0] l_sh, sum_sh, ls_x, m2, m1, dlt;
  logic [hsl2rgb_pkg::HUE_W-1:0] t_red, t_blue;
  hsl2rgb_pkg::helper_t          help_r;
  logic [hsl2rgb_pkg::SEG_W-1:0] f_red_r, f_green_r, f_blue_r;

  always_comb begin
    l_sh   = hsl2rgb_pkg::MX_W'(s2_l_r) << hsl2rgb_pkg::FRAC_BITS;
    sum_sh = (hsl2rgb_pkg::MX_W'(s2_l_r) + hsl2rgb_pkg::MX_W'(s2_s_r)) << hsl2rgb_pkg::FRAC_BITS;
    ls_x   = hsl2rgb_pkg::MX_W'(s2_ls_r);
    m2     = s2_lo_r ? (ls_x + l_sh) : (sum_sh - ls_x);
    m1     = (l_sh << 1) - m2;
    dlt    = m2 - m1;
    t_red  = hsl2rgb_pkg::hue_rot(s2_t_r, hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::HUE_THIRD));
    t_blue = hsl2rgb_pkg::hue_rot(s2_t_r,
               hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::HUE_TURN - hsl2rgb_pkg::HUE_THIRD));
  end

  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::ST_HELP]) begin
      help_r.m1  <= m1[hsl2rgb_pkg::M_W-1:0];
      help_r.dlt <= dlt[hsl2rgb_pkg::M_W-1:0];
      f_red_r    <= hsl2rgb_pkg::seg_frac(t_red);
      f_green_r  <= hsl2rgb_pkg::seg_frac(s2_t_r);
      f_blue_r   <= hsl2rgb_pkg::seg_frac(t_blue);
    end
  end

  assign help    = help_r;
  assign f_red   = f_red_r;
  assign f_green = f_green_r;
  assign f_blue  = f_blue_r;

endmodule

// File: rtl/hsl2rgb_chan.sv
// Per-channel back stages: ramp multiply, scale by 255 with rounding, divide to a byte.
module hsl2rgb_chan (
  input  logic                          clk,
  input  hsl2rgb_pkg::stg_en_t          en,
  input  hsl2rgb_pkg::helper_t          help,
  input  logic [hsl2rgb_pkg::SEG_W-1:0] frac,
  output logic [hsl2rgb_pkg::BYTE_W-1:0] chan_byte
);

  // Stage 4: ramp product and M1 scaled to one segment
  logic [hsl2rgb_pkg::X_W-1:0] prod_r, base_r;

  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::ST_MUL]) begin
      prod_r <= hsl2rgb_pkg::X_W'(help.dlt) * hsl2rgb_pkg::X_W'(frac);
      base_r <= hsl2rgb_pkg::X_W'(help.m1) * hsl2rgb_pkg::X_W'(hsl2rgb_pkg::HUE_SEG);
    end
  end

  // Stage 5: times 255 plus half, drop the power-of-two part of the divisor
  logic [hsl2rgb_pkg::X_W-1:0] x;
  logic [hsl2rgb_pkg::Y_W-1:0] y;
  logic [hsl2rgb_pkg::Z_W-1:0] z_r;

  assign x = base_r + prod_r;
  assign y = (hsl2rgb_pkg::Y_W'(x) << 8) - hsl2rgb_pkg::Y_W'(x) + hsl2rgb_pkg::HALF_Y;

  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::ST_SCALE]) begin
      z_r <= y[hsl2rgb_pkg::Y_W-1:hsl2rgb_pkg::Z_SH];
    end
  end

  // Stage 6: divide by 15 through the reciprocal, clamp to a byte
  logic [2*hsl2rgb_pkg::Z_W-1:0] zq;
  logic [2*hsl2rgb_pkg::Z_W-hsl2rgb_pkg::RECIP_SH-1:0] quo;
  logic [hsl2rgb_pkg::BYTE_W-1:0] byte_r;

  assign zq  = (2*hsl2rgb_pkg::Z_W)'(z_r) * (2*hsl2rgb_pkg::Z_W)'(hsl2rgb_pkg::RECIP_15);
  assign quo = zq[2*hsl2rgb_pkg::Z_W-1:hsl2rgb_pkg::RECIP_SH];

  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::ST_OUT]) begin
      if (quo > (2*hsl2rgb_pkg::Z_W-hsl2rgb_pkg::RECIP_SH)'(255)) begin
        byte_r <= '1;
      end else begin
        byte_r <= quo[hsl2rgb_pkg::BYTE_W-1:0];
      end
    end
  end

  assign chan_byte = byte_r;

endmodule

// File: rtl/hsl_to_rgb_converter_core.sv
// Top level of the HSL(A) to RGB(A) converter: stage control and channel datapaths.
//
// Usage:
//   in_if  (sink)   takes one HSL item per transfer: hue_q4 (signed Q4 degrees,
//                   any value, wrapped modulo 360), saturation and lightness
//                   (unsigned Q12, values above 1.0 are clamped) and alpha_in.
//   out_if (source) gives one RGB item per input item, in order: red, green,
//                   blue rounded half up from 255 * channel value, and
//                   alpha_out copied from alpha_in.
// The pipeline has six stages (wrap, product, helper, multiply, scale, out);
// out_if.valid rises once an input item has been loaded into the out stage.
// Throughput is one item per clock while out_if.ready is high; the six register
// stages each carry a valid bit, so with no stall a new item may enter every cycle.
// When the receiver holds out_if.ready low, the last stage holds its result
// and earlier stages keep advancing into empty slots; in_if.ready drops only
// once every stage is full. Nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; the block comes out of
// reset empty and ready.
module hsl_to_rgb_converter_core (
  input logic          clk,
  input logic          rst_n,
  hsl2rgb_in_if.sink   in_if,
  hsl2rgb_out_if.source out_if
);

  // Valid bits of the six stages and their load enables
  logic [hsl2rgb_pkg::NUM_STG-1:0] vld_r;
  logic [hsl2rgb_pkg::NUM_STG-1:0] vld_nxt;
  hsl2rgb_pkg::stg_en_t            en;

  // A stage loads when it is empty or its content moves on this cycle
  always_comb begin
    en[hsl2rgb_pkg::ST_OUT] = !vld_r[hsl2rgb_pkg::ST_OUT] || out_if.ready;
    for (int k = hsl2rgb_pkg::NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Advance valid bits along with the data; hold them where stalled
  always_comb begin
    for (int k = 0; k < hsl2rgb_pkg::NUM_STG; k++) begin
      if (!en[k]) begin
        vld_nxt[k] = vld_r[k];
      end else if (k == 0) begin
        vld_nxt[k] = in_if.valid;
      end else begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Alpha rides along the stages untouched
  logic [hsl2rgb_pkg::BYTE_W-1:0] alpha_r [hsl2rgb_pkg::NUM_STG];

  always_ff @(posedge clk) begin
    for (int k = 0; k < hsl2rgb_pkg::NUM_STG; k++) begin
      if (en[k]) begin
        if (k == 0) begin
          alpha_r[k] <= in_if.alpha_in;
        end else begin
          alpha_r[k] <= alpha_r[k-1];
        end
      end
    end
  end

  // Shared front: clamp, hue wrap, helper values, ramp positions
  hsl2rgb_pkg::helper_t          help;
  logic [hsl2rgb_pkg::SEG_W-1:0] f_red, f_green, f_blue;

  hsl2rgb_front u_front (
    .clk        (clk),
    .en         (en),
    .hue_q4     (in_if.hue_q4),
    .saturation (in_if.saturation),
    .lightness  (in_if.lightness),
    .help       (help),
    .f_red      (f_red),
    .f_green    (f_green),
    .f_blue     (f_blue)
  );

  // One back end per color channel
  hsl2rgb_chan u_red (
    .clk       (clk),
    .en        (en),
    .help      (help),
    .frac      (f_red),
    .chan_byte (out_if.red)
  );

  hsl2rgb_chan u_green (
    .clk       (clk),
    .en        (en),
    .help      (help),
    .frac      (f_green),
    .chan_byte (out_if.green)
  );

  hsl2rgb_chan u_blue (
    .clk       (clk),
    .en        (en),
    .help      (help),
    .frac      (f_blue),
    .chan_byte (out_if.blue)
  );

  assign in_if.ready      = en[hsl2rgb_pkg::ST_WRAP];
  assign out_if.valid     = vld_r[hsl2rgb_pkg::ST_OUT];
  assign out_if.alpha_out = alpha_r[hsl2rgb_pkg::ST_OUT];

endmodule
